### src/vgbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the video gate and RAM bank mapper.
// No dependencies; used by the result interface, the bank map and the top level.
package vgbm_pkg;

    localparam int PEN_COUNT    = 17;
    localparam int PEN_W        = 5;
    localparam int COLOUR_W     = 5;
    localparam int BLOCK_W      = 6;
    localparam int BANK_COUNT   = 4;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [PEN_W-1:0]   BORDER_PEN     = 5'd16;
    localparam logic [7:0]         MODE_RESET     = 8'h89;
    localparam logic               CMD_GATE_ARRAY = 1'b0;
    localparam logic               CMD_ROM_SELECT = 1'b1;
    localparam logic [PADDR_W-1:0] ADDR_EXP_EN    = 3'd0;

    typedef enum logic [1:0] {
        GA_PEN_SELECT = 2'd0,
        GA_COLOUR     = 2'd1,
        GA_MODE       = 2'd2,
        GA_RAM_CONFIG = 2'd3
    } t_ga_op;

    typedef logic [BLOCK_W-1:0] t_block_map [BANK_COUNT];

    typedef struct packed {
        logic [BLOCK_W-1:0]  bank0_block;
        logic [BLOCK_W-1:0]  bank1_block;
        logic [BLOCK_W-1:0]  bank2_block;
        logic [BLOCK_W-1:0]  bank3_block;
        logic                lower_rom_on;
        logic                upper_rom_on;
        logic [7:0]          upper_rom_number;
        logic [1:0]          screen_mode;
        logic [PEN_W-1:0]    pen_index;
        logic [COLOUR_W-1:0] pen_colour;
        logic                refresh_needed;
        logic                irq_clear;
    } t_result;

    // base block per RAM configuration and bank; values of 4 and up come from the
    // expansion block
    function automatic logic [2:0] base_block(input logic [2:0] cfg, input logic [1:0] bank);
        logic [11:0] row;
        case (cfg)
            3'd0:    row = {3'd3, 3'd2, 3'd1, 3'd0};
            3'd1:    row = {3'd7, 3'd2, 3'd1, 3'd0};
            3'd2:    row = {3'd7, 3'd6, 3'd5, 3'd4};
            3'd3:    row = {3'd7, 3'd2, 3'd3, 3'd0};
            3'd4:    row = {3'd3, 3'd2, 3'd4, 3'd0};
            3'd5:    row = {3'd3, 3'd2, 3'd5, 3'd0};
            3'd6:    row = {3'd3, 3'd2, 3'd6, 3'd0};
            3'd7:    row = {3'd3, 3'd2, 3'd7, 3'd0};
            default: row = '0;
        endcase
        return row[bank*3 +: 3];
    endfunction

endpackage

### src/vgbm_cmd_if.sv
`timescale 1ns / 1ps
// Input channel: one port write (command select and data byte) per item.
// No dependencies.
interface vgbm_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

### src/vgbm_res_if.sv
`timescale 1ns / 1ps
// Result channel: bank map and video status after each write.
// Depends on vgbm_pkg for field widths.
interface vgbm_res_if;
    logic                          valid;
    logic                          ready;
    logic [vgbm_pkg::BLOCK_W-1:0]  bank0_block;
    logic [vgbm_pkg::BLOCK_W-1:0]  bank1_block;
    logic [vgbm_pkg::BLOCK_W-1:0]  bank2_block;
    logic [vgbm_pkg::BLOCK_W-1:0]  bank3_block;
    logic                          lower_rom_on;
    logic                          upper_rom_on;
    logic [7:0]                    upper_rom_number;
    logic [1:0]                    screen_mode;
    logic [vgbm_pkg::PEN_W-1:0]    pen_index;
    logic [vgbm_pkg::COLOUR_W-1:0] pen_colour;
    logic                          refresh_needed;
    logic                          irq_clear;

    modport source (
        output valid, output bank0_block, output bank1_block, output bank2_block,
        output bank3_block, output lower_rom_on, output upper_rom_on,
        output upper_rom_number, output screen_mode, output pen_index,
        output pen_colour, output refresh_needed, output irq_clear, input ready
    );
    modport sink (
        input valid, input bank0_block, input bank1_block, input bank2_block,
        input bank3_block, input lower_rom_on, input upper_rom_on,
        input upper_rom_number, input screen_mode, input pen_index,
        input pen_colour, input refresh_needed, input irq_clear, output ready
    );
endinterface

### src/vgbm_bank_map.sv
`timescale 1ns / 1ps
// Bank map decode: 16K block number for each bank from RAM config and expansion block.
// Depends on vgbm_pkg.
module vgbm_bank_map (
    input  logic [2:0]           i_ram_config,
    input  logic [2:0]           i_exp_block,
    output vgbm_pkg::t_block_map o_blocks
);

    logic [3:0] exp_base;

    assign exp_base = {1'b0, i_exp_block} + 4'd1;

    always_comb begin
        logic [2:0] b;
        for (int i = 0; i < vgbm_pkg::BANK_COUNT; i++) begin
            b = vgbm_pkg::base_block(i_ram_config, 2'(i));
            if (b[2]) begin
                o_blocks[i] = {exp_base, b[1:0]};
            end else begin
                o_blocks[i] = {3'd0, b};
            end
        end
    end

endmodule

### src/video_gate_and_ram_bank_mapper_top.sv
`timescale 1ns / 1ps
// Top level of the video gate and RAM bank mapper.
// Depends on vgbm_pkg, vgbm_cmd_if, vgbm_res_if and vgbm_bank_map.
//
// Each accepted item is one processor write, either to the gate array (pen select,
// pen colour, mode and ROM enable, RAM configuration) or to the upper ROM number
// port. The registers are updated at the accepting edge and one result item, the
// bank map and video status after that write, appears in the output register on
// the next cycle. A new item is taken every cycle: the decode and bank map lookup
// are one level of logic between the channel and the output register, and input
// is only held back while the output register is full and not being taken. The
// APB register at address 0 holds the expansion enable bit (reset 1); pready is
// always high and writes take effect on the access cycle.
module video_gate_and_ram_bank_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    vgbm_cmd_if.sink                            i_cmd_ch,
    vgbm_res_if.source                          o_res_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vgbm_pkg::PADDR_W-1:0]        paddr,
    input  logic [vgbm_pkg::PDATA_W-1:0]        pwdata,
    output logic [vgbm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic                          r_exp_en;
    logic [vgbm_pkg::PEN_W-1:0]    r_sel_pen;
    logic [vgbm_pkg::COLOUR_W-1:0] r_palette [vgbm_pkg::PEN_COUNT];
    logic [7:0]                    r_mode;
    logic [2:0]                    r_ram_cfg;
    logic [2:0]                    r_exp_blk;
    logic [7:0]                    r_rom_num;
    logic                          r_out_valid;
    vgbm_pkg::t_result             r_out;

    logic [vgbm_pkg::PEN_W-1:0]    n_sel_pen;
    logic [vgbm_pkg::COLOUR_W-1:0] n_palette [vgbm_pkg::PEN_COUNT];
    logic [7:0]                    n_mode;
    logic [2:0]                    n_ram_cfg;
    logic [2:0]                    n_exp_blk;
    logic [7:0]                    n_rom_num;
    vgbm_pkg::t_result             n_out;

    logic                          accept;
    logic                          refresh;
    logic                          irq;
    vgbm_pkg::t_ga_op              op;
    vgbm_pkg::t_block_map          blocks;

    assign pready = 1'b1;
    assign prdata = (paddr == vgbm_pkg::ADDR_EXP_EN) ?
                    {{(vgbm_pkg::PDATA_W-1){1'b0}}, r_exp_en} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_en <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == vgbm_pkg::ADDR_EXP_EN) begin
            r_exp_en <= pwdata[0];
        end
    end

    assign i_cmd_ch.ready = !r_out_valid || o_res_ch.ready;
    assign accept         = i_cmd_ch.valid && i_cmd_ch.ready;
    assign op             = vgbm_pkg::t_ga_op'(i_cmd_ch.value[7:6]);

    always_comb begin
        n_sel_pen = r_sel_pen;
        n_palette = r_palette;
        n_mode    = r_mode;
        n_ram_cfg = r_ram_cfg;
        n_exp_blk = r_exp_blk;
        n_rom_num = r_rom_num;
        refresh   = 1'b0;
        irq       = 1'b0;
        if (i_cmd_ch.command == vgbm_pkg::CMD_ROM_SELECT) begin
            n_rom_num = i_cmd_ch.value;
        end else begin
            case (op)
                vgbm_pkg::GA_PEN_SELECT: begin
                    n_sel_pen = i_cmd_ch.value[4] ? vgbm_pkg::BORDER_PEN
                                                  : {1'b0, i_cmd_ch.value[3:0]};
                end
                vgbm_pkg::GA_COLOUR: begin
                    if (r_palette[r_sel_pen] != i_cmd_ch.value[4:0]) begin
                        n_palette[r_sel_pen] = i_cmd_ch.value[4:0];
                        refresh              = 1'b1;
                    end
                end
                vgbm_pkg::GA_MODE: begin
                    n_mode  = i_cmd_ch.value;
                    irq     = i_cmd_ch.value[4];
                    refresh = 1'b1;
                end
                vgbm_pkg::GA_RAM_CONFIG: begin
                    n_ram_cfg = i_cmd_ch.value[2:0];
                    n_exp_blk = r_exp_en ? i_cmd_ch.value[5:3] : 3'd0;
                    refresh   = 1'b1;
                end
                default: begin
                    refresh = 1'b0;
                end
            endcase
        end
    end

    vgbm_bank_map u_bank_map (
        .i_ram_config (n_ram_cfg),
        .i_exp_block  (n_exp_blk),
        .o_blocks     (blocks)
    );

    always_comb begin
        n_out.bank0_block      = blocks[0];
        n_out.bank1_block      = blocks[1];
        n_out.bank2_block      = blocks[2];
        n_out.bank3_block      = blocks[3];
        n_out.lower_rom_on     = !n_mode[2];
        n_out.upper_rom_on     = !n_mode[3];
        n_out.upper_rom_number = n_rom_num;
        n_out.screen_mode      = n_mode[1:0];
        n_out.pen_index        = n_sel_pen;
        n_out.pen_colour       = n_palette[n_sel_pen];
        n_out.refresh_needed   = refresh;
        n_out.irq_clear        = irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_pen   <= '0;
            r_mode      <= vgbm_pkg::MODE_RESET;
            r_ram_cfg   <= '0;
            r_exp_blk   <= '0;
            r_rom_num   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < vgbm_pkg::PEN_COUNT; i++) begin
                r_palette[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_sel_pen <= n_sel_pen;
                r_palette <= n_palette;
                r_mode    <= n_mode;
                r_ram_cfg <= n_ram_cfg;
                r_exp_blk <= n_exp_blk;
                r_rom_num <= n_rom_num;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_res_ch.valid            = r_out_valid;
    assign o_res_ch.bank0_block      = r_out.bank0_block;
    assign o_res_ch.bank1_block      = r_out.bank1_block;
    assign o_res_ch.bank2_block      = r_out.bank2_block;
    assign o_res_ch.bank3_block      = r_out.bank3_block;
    assign o_res_ch.lower_rom_on     = r_out.lower_rom_on;
    assign o_res_ch.upper_rom_on     = r_out.upper_rom_on;
    assign o_res_ch.upper_rom_number = r_out.upper_rom_number;
    assign o_res_ch.screen_mode      = r_out.screen_mode;
    assign o_res_ch.pen_index        = r_out.pen_index;
    assign o_res_ch.pen_colour       = r_out.pen_colour;
    assign o_res_ch.refresh_needed   = r_out.refresh_needed;
    assign o_res_ch.irq_clear        = r_out.irq_clear;

endmodule
